// ===== hdl/apt_pkg.sv =====
// ----------------------------------------------------------------------------
// apt_pkg
// Shared types and constants of the affine point transform: request and
// response payloads, arithmetic widths and pipeline control.
// ----------------------------------------------------------------------------
package apt_pkg;

   // Number format: signed Q16.16
   localparam int DATA_WIDTH     = 32;
   localparam int FRAC_BITS      = 16;
   localparam int NUM_COEFS      = 12;
   localparam int NUM_AXES       = 3;
   localparam int COEF_IDX_WIDTH = 4;
   localparam int TRANS_BASE     = 9;

   // Full width of one product, of a pair sum and of the final sum
   localparam int PROD_WIDTH = 2 * DATA_WIDTH;
   localparam int PART_WIDTH = PROD_WIDTH + 1;
   localparam int SUM_WIDTH  = PROD_WIDTH + 2;

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_XFORM = 1'b1;

   typedef logic signed [DATA_WIDTH-1:0] word_type;
   typedef logic signed [PROD_WIDTH-1:0] prod_type;
   typedef logic signed [PART_WIDTH-1:0] part_type;
   typedef logic signed [SUM_WIDTH-1:0]  sum_type;

   // 1.0 in the fixed point format
   localparam word_type COEF_ONE = word_type'(1) <<< FRAC_BITS;

   typedef struct packed {
      logic                      kind;
      logic [COEF_IDX_WIDTH-1:0] coef_index;
      logic signed [31:0]        coef_value;
      logic signed [31:0]        point_x;
      logic signed [31:0]        point_y;
      logic signed [31:0]        point_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
   } rsp_type;

   // Per-stage control: load enable and incoming valid
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctl_type;

endpackage

// ===== hdl/apt_coef_bank.sv =====
// ----------------------------------------------------------------------------
// apt_coef_bank
// Twelve coefficient registers: 3x3 linear part plus translation. Reset
// loads the identity matrix with zero translation.
// ----------------------------------------------------------------------------
module apt_coef_bank
   import apt_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      wr_en,
   input  logic [COEF_IDX_WIDTH-1:0] wr_index,
   input  word_type                  wr_value,
   output word_type                  coef [NUM_COEFS]
);

   word_type coef_ff [NUM_COEFS];
   word_type coef_in [NUM_COEFS];

   // Write decode; slots 12..15 match nothing and are dropped
   always_comb begin
      for (int i = 0; i < NUM_COEFS; i++) begin
         coef_in[i] = coef_ff[i];
         if (wr_en && (wr_index == COEF_IDX_WIDTH'(i))) begin
            coef_in[i] = wr_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= ((i == 0) || (i == 4) || (i == 8)) ? COEF_ONE : '0;
         end
      end else begin
         coef_ff <= coef_in;
      end
   end

   assign coef = coef_ff;

endmodule

// ===== hdl/apt_mul.sv =====
// ----------------------------------------------------------------------------
// apt_mul
// First pipeline stage: nine signed 32x32 products of point and linear
// coefficients, with the translation terms carried alongside.
// ----------------------------------------------------------------------------
module apt_mul
   import apt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  word_type      point_x,
   input  word_type      point_y,
   input  word_type      point_z,
   input  word_type      coef [NUM_COEFS],
   output logic          valid,
   output prod_type      prod [NUM_AXES*NUM_AXES],
   output word_type      trans [NUM_AXES]
);

   logic     valid_ff;
   prod_type prod_ff [NUM_AXES*NUM_AXES];
   prod_type prod_in [NUM_AXES*NUM_AXES];
   word_type trans_ff [NUM_AXES];
   word_type pt [NUM_AXES];

   assign pt[0] = point_x;
   assign pt[1] = point_y;
   assign pt[2] = point_z;

   // Row r of the matrix scales input coordinate r
   always_comb begin
      for (int r = 0; r < NUM_AXES; r++) begin
         for (int c = 0; c < NUM_AXES; c++) begin
            prod_in[r*NUM_AXES+c] = PROD_WIDTH'(pt[r]) * PROD_WIDTH'(coef[r*NUM_AXES+c]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.valid) begin
         prod_ff <= prod_in;
         for (int c = 0; c < NUM_AXES; c++) begin
            trans_ff[c] <= coef[TRANS_BASE+c];
         end
      end
   end

   assign valid = valid_ff;
   assign prod  = prod_ff;
   assign trans = trans_ff;

endmodule

// ===== hdl/apt_sum.sv =====
// ----------------------------------------------------------------------------
// apt_sum
// Two adder stages per axis: pair sums first, then the full-width total of
// three products and the scaled translation.
// ----------------------------------------------------------------------------
module apt_sum
   import apt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl_pair,
   input  stage_ctl_type ctl_total,
   input  prod_type      prod [NUM_AXES*NUM_AXES],
   input  word_type      trans [NUM_AXES],
   output logic          pair_valid,
   output logic          valid,
   output sum_type       sum [NUM_AXES]
);

   logic     pair_valid_ff;
   logic     valid_ff;
   part_type pa_ff [NUM_AXES];
   part_type pb_ff [NUM_AXES];
   part_type pa_in [NUM_AXES];
   part_type pb_in [NUM_AXES];
   sum_type  sum_ff [NUM_AXES];
   sum_type  sum_in [NUM_AXES];

   // Pair stage: x and y terms, z term and translation
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         pa_in[c] = PART_WIDTH'(prod[c]) + PART_WIDTH'(prod[NUM_AXES+c]);
         pb_in[c] = PART_WIDTH'(prod[2*NUM_AXES+c])
                  + (PART_WIDTH'(trans[c]) <<< FRAC_BITS);
      end
   end

   // Total stage
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         sum_in[c] = SUM_WIDTH'(pa_ff[c]) + SUM_WIDTH'(pb_ff[c]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pair_valid_ff <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         if (ctl_pair.advance) begin
            pair_valid_ff <= ctl_pair.valid;
         end
         if (ctl_total.advance) begin
            valid_ff <= ctl_total.valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_pair.advance && ctl_pair.valid) begin
         pa_ff <= pa_in;
         pb_ff <= pb_in;
      end
      if (ctl_total.advance && ctl_total.valid) begin
         sum_ff <= sum_in;
      end
   end

   assign pair_valid = pair_valid_ff;
   assign valid      = valid_ff;
   assign sum        = sum_ff;

endmodule

// ===== hdl/apt_sat.sv =====
// ----------------------------------------------------------------------------
// apt_sat
// Output stage: arithmetic shift by the fraction width, clamp to 32 bits,
// flag any clamp, and hold the response until it is taken.
// ----------------------------------------------------------------------------
module apt_sat
   import apt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  stage_ctl_type ctl,
   input  sum_type       sum [NUM_AXES],
   output logic          valid,
   output rsp_type       rsp
);

   localparam word_type MAX_WORD = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam word_type MIN_WORD = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   logic     valid_ff;
   rsp_type  rsp_ff;
   rsp_type  rsp_in;
   sum_type  shifted [NUM_AXES];
   word_type coord [NUM_AXES];
   logic     clamp [NUM_AXES];

   // In range when every bit from the sign of a word upward agrees
   always_comb begin
      for (int c = 0; c < NUM_AXES; c++) begin
         shifted[c] = sum[c] >>> FRAC_BITS;
         clamp[c]   = !((&shifted[c][SUM_WIDTH-1:DATA_WIDTH-1])
                     || !(|shifted[c][SUM_WIDTH-1:DATA_WIDTH-1]));
         if (!clamp[c]) begin
            coord[c] = shifted[c][DATA_WIDTH-1:0];
         end else if (sum[c][SUM_WIDTH-1]) begin
            coord[c] = MIN_WORD;
         end else begin
            coord[c] = MAX_WORD;
         end
      end
      rsp_in.out_x     = coord[0];
      rsp_in.out_y     = coord[1];
      rsp_in.out_z     = coord[2];
      rsp_in.saturated = clamp[0] || clamp[1] || clamp[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.advance) begin
         valid_ff <= ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance && ctl.valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign valid = valid_ff;
   assign rsp   = rsp_ff;

endmodule

// ===== hdl/affine_point_transform.sv =====
// Transform requests pass four register stages (multiply, pair add, total add,
// shift/saturate) to rsp_valid, one per cycle unless the output stalls; each
// stage moves when the stage after it has room.
// Load requests write a coefficient at acceptance and give no response.
// Synchronous reset empties the pipeline and restores the identity matrix.
// ----------------------------------------------------------------------------
// affine_point_transform
// Transforms Q16.16 points by a stored 4x3 affine matrix, with coefficient
// loads and transforms sharing one request channel.
// ----------------------------------------------------------------------------
module affine_point_transform
   import apt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   word_type      coef [NUM_COEFS];
   prod_type      prod [NUM_AXES*NUM_AXES];
   word_type      trans [NUM_AXES];
   sum_type       sum [NUM_AXES];
   logic          mul_valid;
   logic          pair_valid;
   logic          sum_valid;
   logic          req_fire;
   stage_ctl_type ctl_mul;
   stage_ctl_type ctl_pair;
   stage_ctl_type ctl_total;
   stage_ctl_type ctl_out;

   // Backpressure: a stage loads when it is empty or its successor loads
   assign ctl_out.advance   = !rsp_valid || rsp_ready;
   assign ctl_out.valid     = sum_valid;
   assign ctl_total.advance = !sum_valid || ctl_out.advance;
   assign ctl_total.valid   = pair_valid;
   assign ctl_pair.advance  = !pair_valid || ctl_total.advance;
   assign ctl_pair.valid    = mul_valid;
   assign ctl_mul.advance   = !mul_valid || ctl_pair.advance;
   assign ctl_mul.valid     = req_valid && (req_data.kind == KIND_XFORM);

   assign req_ready = ctl_mul.advance;
   assign req_fire  = req_valid && req_ready;

   apt_coef_bank u_coef_bank (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (req_fire && (req_data.kind == KIND_LOAD)),
      .wr_index (req_data.coef_index),
      .wr_value (req_data.coef_value),
      .coef     (coef)
   );

   apt_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ctl_mul),
      .point_x (req_data.point_x),
      .point_y (req_data.point_y),
      .point_z (req_data.point_z),
      .coef    (coef),
      .valid   (mul_valid),
      .prod    (prod),
      .trans   (trans)
   );

   apt_sum u_sum (
      .clock      (clock),
      .reset      (reset),
      .ctl_pair   (ctl_pair),
      .ctl_total  (ctl_total),
      .prod       (prod),
      .trans      (trans),
      .pair_valid (pair_valid),
      .valid      (sum_valid),
      .sum        (sum)
   );

   apt_sat u_sat (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl_out),
      .sum   (sum),
      .valid (rsp_valid),
      .rsp   (rsp_data)
   );

`ifndef SYNTH
   // An accepted transform occupies the multiply stage next cycle
   a_xform_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire && (req_data.kind == KIND_XFORM) |=> mul_valid)
      else $error("transform request did not enter the pipeline");

   // Requests are refused only when every stage holds an item
   a_no_bubble_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> mul_valid && pair_valid && sum_valid && rsp_valid)
      else $error("request stalled with a bubble in the pipeline");

   // A clamp flag means some coordinate sits at a limit
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.saturated |->
         rsp_data.out_x == 32'sh7fffffff || rsp_data.out_x == 32'sh80000000 ||
         rsp_data.out_y == 32'sh7fffffff || rsp_data.out_y == 32'sh80000000 ||
         rsp_data.out_z == 32'sh7fffffff || rsp_data.out_z == 32'sh80000000)
      else $error("saturated flag without a clamped coordinate");

   // Reset leaves the pipeline empty and the diagonal at one
   a_reset_state: assert property (@(posedge clock)
      $past(reset) && !reset |->
         !mul_valid && !rsp_valid && coef[0] == COEF_ONE && coef[4] == COEF_ONE
         && coef[8] == COEF_ONE && coef[1] == '0 && coef[TRANS_BASE] == '0)
      else $error("reset state incorrect");
`endif

endmodule
